/* hdl/mbsma_pkg.sv */
// Package for the MIDI byte stream message assembler.
// Holds the status byte codes, the parser state and message types, and the data count lookup.
// No dependencies.
package mbsma_pkg;

	localparam logic [7:0] SX_START   = 8'hF0;
	localparam logic [7:0] SX_END     = 8'hF7;
	localparam logic [7:0] TUNE_REQ   = 8'hF6;
	localparam logic [7:0] RT_FIRST   = 8'hF8;
	localparam logic [7:0] RT_UNDEF_A = 8'hF9;
	localparam logic [7:0] RT_UNDEF_B = 8'hFD;
	localparam logic [7:0] CHAN_FIRST = 8'h80;
	localparam logic [7:0] CHAN_LAST  = 8'hEF;

	localparam logic [1:0] COUNT_UNKNOWN = 2'd3;

	typedef struct packed {
		logic       sync;
		logic [7:0] cur;
		logic [7:0] rs;
		logic [6:0] d0;
		logic [6:0] d1;
		logic [1:0] exp;
		logic [1:0] rcv;
	} state_t;

	localparam state_t STATE_RESET = '0;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] first;
		logic [6:0] second;
		logic [1:0] count;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic emit;
		logic retry;
	} step_ctl_t;

	function automatic logic [1:0] data_count_for(input logic [7:0] s);
		logic [1:0] n;
		n = COUNT_UNKNOWN;
		case (s[7:4])
			4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
			4'hC, 4'hD: n = 2'd1;
			4'hF: begin
				case (s[3:0])
					4'h1: n = 2'd1;
					4'h2: n = 2'd2;
					4'h3: n = 2'd1;
					4'h6: n = 2'd0;
					default: n = COUNT_UNKNOWN;
				endcase
			end
			default: n = COUNT_UNKNOWN;
		endcase
		return n;
	endfunction

endpackage

/* hdl/midi_byte_stream_message_assembler.sv */
// Top level of the MIDI byte stream message assembler: input register, parser state and
// message output register. Depends on mbsma_pkg and mbsma_step.
//
//   channel  | handshake            | payload
//   byte     | byte_valid/byte_stall | rx_byte
//   msg      | msg_valid/msg_stall   | msg_status, msg_first_data, msg_second_data,
//            |                       | msg_data_count, msg_last
//
// A taken byte is held in the input register and parsed from there into the message register;
// one byte can be taken in every cycle unless the output stalls or a byte is parsed twice.
// A non-real-time status byte other than EOX that interrupts a system exclusive message is
// parsed twice: first for the EOX and then for the byte itself.
// The parser advances only while the message register is empty or being emptied.
// Reset returns the parser to waiting for a status byte and empties both registers.
module midi_byte_stream_message_assembler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] rx_byte,
	output logic       msg_valid,
	input  logic       msg_stall,
	output logic [7:0] msg_status,
	output logic [6:0] msg_first_data,
	output logic [6:0] msg_second_data,
	output logic [1:0] msg_data_count,
	output logic       msg_last
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	mbsma_pkg::state_t     state_q;
	mbsma_pkg::state_t     state_nxt;
	mbsma_pkg::msg_t       res;
	mbsma_pkg::msg_t       msg_q;
	mbsma_pkg::step_ctl_t  ctl;
	logic                  msg_valid_q;
	logic                  out_free;
	logic                  step_go;
	logic                  s1_done;
	logic                  accept;

	mbsma_step u_step (
		.rx_byte (byte_s1),
		.st      (state_q),
		.nxt     (state_nxt),
		.res     (res),
		.ctl     (ctl)
	);

	assign out_free   = !msg_valid_q || !msg_stall;
	assign step_go    = valid_s1 && out_free;
	assign s1_done    = step_go && !ctl.retry;
	assign byte_stall = valid_s1 && !s1_done;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= mbsma_pkg::STATE_RESET;
			msg_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !s1_done);
			if (step_go) begin
				state_q <= state_nxt;
			end
			if (step_go && ctl.emit) begin
				msg_valid_q <= 1'b1;
			end else if (!msg_stall) begin
				msg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
		if (step_go && ctl.emit) begin
			msg_q <= res;
		end
	end

	assign msg_valid       = msg_valid_q;
	assign msg_status      = msg_q.status;
	assign msg_first_data  = msg_q.first;
	assign msg_second_data = msg_q.second;
	assign msg_data_count  = msg_q.count;
	assign msg_last        = msg_q.last;

endmodule

/* hdl/mbsma_step.sv */
// Next-state and message logic for one received MIDI byte.
// Depends on mbsma_pkg for the state and message types and the data count lookup.
module mbsma_step (
	input  logic [7:0]          rx_byte,
	input  mbsma_pkg::state_t   st,
	output mbsma_pkg::state_t   nxt,
	output mbsma_pkg::msg_t     res,
	output mbsma_pkg::step_ctl_t ctl
);

	logic [1:0] n_cnt;
	logic [1:0] rs_cnt;
	logic [7:0] eff_cur;
	logic [1:0] eff_exp;
	logic [1:0] eff_rcv;
	logic [6:0] d0n;
	logic [6:0] d1n;

	assign n_cnt  = mbsma_pkg::data_count_for(rx_byte);
	assign rs_cnt = mbsma_pkg::data_count_for(st.rs);

	always_comb begin
		nxt     = st;
		res     = '0;
		ctl     = '0;
		eff_cur = st.cur;
		eff_exp = st.exp;
		eff_rcv = st.rcv;
		d0n     = st.d0;
		d1n     = st.d1;
		if (rx_byte >= mbsma_pkg::RT_FIRST) begin
			if (rx_byte != mbsma_pkg::RT_UNDEF_A && rx_byte != mbsma_pkg::RT_UNDEF_B) begin
				ctl.emit   = 1'b1;
				res.status = rx_byte;
				res.last   = 1'b1;
			end
		end else if (!st.sync && (!rx_byte[7] || rx_byte == mbsma_pkg::SX_END)) begin
			nxt = st;
		end else if (st.cur == mbsma_pkg::SX_START) begin
			nxt.sync = 1'b1;
			ctl.emit = 1'b1;
			if (!rx_byte[7]) begin
				res.status = mbsma_pkg::SX_START;
				res.first  = rx_byte[6:0];
				res.count  = 2'd1;
				res.last   = 1'b1;
			end else begin
				// The interrupting status byte stays in the input register and is handled again.
				res.status = mbsma_pkg::SX_END;
				res.last   = (rx_byte == mbsma_pkg::SX_END) ||
					!(rx_byte == mbsma_pkg::SX_START || rx_byte == mbsma_pkg::TUNE_REQ);
				nxt.cur    = '0;
				nxt.rs     = '0;
				ctl.retry  = (rx_byte != mbsma_pkg::SX_END);
			end
		end else if (rx_byte[7]) begin
			nxt.sync = 1'b1;
			if (st.cur[7]) begin
				nxt = mbsma_pkg::STATE_RESET;
			end else if (rx_byte == mbsma_pkg::SX_START) begin
				nxt.cur    = mbsma_pkg::SX_START;
				ctl.emit   = 1'b1;
				res.status = mbsma_pkg::SX_START;
				res.last   = 1'b1;
			end else if (n_cnt == mbsma_pkg::COUNT_UNKNOWN) begin
				nxt = mbsma_pkg::STATE_RESET;
			end else if (n_cnt == 2'd0) begin
				ctl.emit   = 1'b1;
				res.status = rx_byte;
				res.last   = 1'b1;
				nxt.cur    = '0;
				nxt.rs     = '0;
				nxt.exp    = 2'd0;
				nxt.rcv    = 2'd0;
			end else begin
				nxt.cur = rx_byte;
				nxt.exp = n_cnt;
				nxt.rcv = 2'd0;
			end
		end else begin
			nxt.sync = 1'b1;
			if (!st.cur[7] && !st.rs[7]) begin
				nxt = mbsma_pkg::STATE_RESET;
			end else begin
				if (!st.cur[7]) begin
					eff_cur = st.rs;
					eff_exp = rs_cnt;
					eff_rcv = 2'd0;
				end
				if (eff_rcv < 2'd2) begin
					if (eff_rcv == 2'd0) begin
						d0n = rx_byte[6:0];
					end else begin
						d1n = rx_byte[6:0];
					end
					eff_rcv = 2'(eff_rcv + 2'd1);
				end
				nxt.d0  = d0n;
				nxt.d1  = d1n;
				nxt.rcv = eff_rcv;
				nxt.exp = eff_exp;
				if (eff_rcv >= eff_exp) begin
					ctl.emit   = 1'b1;
					res.status = eff_cur;
					res.first  = (eff_exp >= 2'd1) ? d0n : 7'd0;
					res.second = (eff_exp >= 2'd2) ? d1n : 7'd0;
					res.count  = eff_exp;
					res.last   = 1'b1;
					nxt.cur    = '0;
					nxt.rs     = (eff_cur >= mbsma_pkg::CHAN_FIRST &&
						eff_cur <= mbsma_pkg::CHAN_LAST) ? eff_cur : 8'd0;
				end else begin
					nxt.cur = eff_cur;
				end
			end
		end
	end

endmodule

/* hdl/mbsma_checker.sv */
// Port checker for the MIDI byte stream message assembler, bound to the top level.
// Depends on mbsma_pkg for the status byte codes.
module mbsma_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_stall,
	input logic [7:0] msg_status,
	input logic [6:0] msg_first_data,
	input logic [6:0] msg_second_data,
	input logic [1:0] msg_data_count,
	input logic       msg_last
);

	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_stall |=> msg_valid && $stable(msg_status) &&
		$stable(msg_first_data) && $stable(msg_second_data) && $stable(msg_last))
		else $error("Stalled message changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> msg_status[7] && msg_data_count != 2'd3)
		else $error("Message has no status byte or a bad data count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> (msg_data_count >= 2'd2 || msg_second_data == 7'd0) &&
		(msg_data_count >= 2'd1 || msg_first_data == 7'd0))
		else $error("Absent data byte is not zero.");

	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && (msg_status >= mbsma_pkg::RT_FIRST || msg_data_count != 2'd0) |-> msg_last)
		else $error("Real-time or data-carrying message is not the last result.");

endmodule

bind midi_byte_stream_message_assembler mbsma_checker u_mbsma_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.msg_valid       (msg_valid),
	.msg_stall       (msg_stall),
	.msg_status      (msg_status),
	.msg_first_data  (msg_first_data),
	.msg_second_data (msg_second_data),
	.msg_data_count  (msg_data_count),
	.msg_last        (msg_last)
);

/* tb/midi_msg_checker.sv */
`timescale 1ns / 1ps
// Checker for the MIDI byte stream message assembler: watches both channels, parses the
// accepted bytes into expected messages and compares every accepted message transaction.
// Depends on mbsma_pkg.
module midi_msg_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] rx_byte,
	input  logic       msg_valid,
	input  logic       msg_stall,
	input  logic [7:0] msg_status,
	input  logic [6:0] msg_first_data,
	input  logic [6:0] msg_second_data,
	input  logic [1:0] msg_data_count,
	input  logic       msg_last,
	output int         fail_count,
	output int         outstanding
);

	localparam logic [7:0] MTC_QUARTER   = 8'hF1;
	localparam logic [7:0] SONG_POSITION = 8'hF2;
	localparam logic [7:0] SONG_SELECT   = 8'hF3;
	localparam logic [3:0] PROG_CHANGE   = 4'hC;
	localparam logic [3:0] CHAN_PRESSURE = 4'hD;

	logic                synced;
	logic [7:0]          open_status;
	logic [7:0]          prev_status;
	logic [6:0]          held_data [2];
	logic [1:0]          need_count;
	logic [1:0]          got_count;
	mbsma_pkg::msg_t     awaited_msgs [$];
	int                  errors;

	function automatic logic [1:0] status_data_len(input logic [7:0] s);
		if (s >= mbsma_pkg::CHAN_FIRST && s <= mbsma_pkg::CHAN_LAST) begin
			return (s[7:4] == PROG_CHANGE || s[7:4] == CHAN_PRESSURE) ? 2'd1 : 2'd2;
		end
		case (s)
			MTC_QUARTER, SONG_SELECT: return 2'd1;
			SONG_POSITION: return 2'd2;
			mbsma_pkg::TUNE_REQ: return 2'd0;
			default: return mbsma_pkg::COUNT_UNKNOWN;
		endcase
	endfunction

	function automatic mbsma_pkg::msg_t make_msg(input logic [7:0] st, input logic [6:0] a,
		input logic [6:0] b, input logic [1:0] cnt, input logic fin);
		mbsma_pkg::msg_t m;
		m.status = st;
		m.first  = a;
		m.second = b;
		m.count  = cnt;
		m.last   = fin;
		return m;
	endfunction

	task automatic lose_sync();
		synced       = 1'b0;
		open_status  = '0;
		prev_status  = '0;
		held_data[0] = '0;
		held_data[1] = '0;
		need_count   = '0;
		got_count    = '0;
	endtask

	task automatic assemble_byte(input logic [7:0] b, output logic made,
		output mbsma_pkg::msg_t m);
		logic [1:0] n;
		made = 1'b0;
		m    = '0;
		if (b[7]) begin
			if (open_status[7]) begin
				lose_sync();
				return;
			end
			if (b == mbsma_pkg::SX_START) begin
				open_status = mbsma_pkg::SX_START;
				m           = make_msg(mbsma_pkg::SX_START, '0, '0, 2'd0, 1'b1);
				made        = 1'b1;
				return;
			end
			n = status_data_len(b);
			if (n == mbsma_pkg::COUNT_UNKNOWN) begin
				lose_sync();
				return;
			end
			open_status = b;
			need_count  = n;
			got_count   = '0;
		end else begin
			if (!open_status[7]) begin
				if (!prev_status[7]) begin
					lose_sync();
					return;
				end
				open_status = prev_status;
				need_count  = status_data_len(prev_status);
				got_count   = '0;
			end
			if (got_count < 2'd2) begin
				held_data[got_count[0]] = b[6:0];
				got_count               = got_count + 2'd1;
			end
		end
		if (got_count < need_count) begin
			return;
		end
		m = make_msg(open_status, (need_count >= 2'd1) ? held_data[0] : 7'd0,
			(need_count >= 2'd2) ? held_data[1] : 7'd0, need_count, 1'b1);
		made = 1'b1;
		if (open_status >= mbsma_pkg::CHAN_FIRST && open_status <= mbsma_pkg::CHAN_LAST) begin
			prev_status = open_status;
		end else begin
			prev_status = '0;
		end
		open_status = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic            made;
		mbsma_pkg::msg_t m;
		mbsma_pkg::msg_t eox;
		if (b >= mbsma_pkg::RT_FIRST) begin
			if (b != mbsma_pkg::RT_UNDEF_A && b != mbsma_pkg::RT_UNDEF_B) begin
				awaited_msgs.push_back(make_msg(b, '0, '0, 2'd0, 1'b1));
			end
			return;
		end
		if (!synced) begin
			if (!b[7] || b == mbsma_pkg::SX_END) begin
				return;
			end
			synced = 1'b1;
		end
		if (open_status == mbsma_pkg::SX_START) begin
			if (!b[7]) begin
				awaited_msgs.push_back(make_msg(mbsma_pkg::SX_START, b[6:0], '0, 2'd1, 1'b1));
				return;
			end
			eox         = make_msg(mbsma_pkg::SX_END, '0, '0, 2'd0, 1'b1);
			open_status = '0;
			prev_status = '0;
			if (b == mbsma_pkg::SX_END) begin
				awaited_msgs.push_back(eox);
				return;
			end
			assemble_byte(b, made, m);
			eox.last = !made;
			awaited_msgs.push_back(eox);
			if (made) begin
				awaited_msgs.push_back(m);
			end
			return;
		end
		assemble_byte(b, made, m);
		if (made) begin
			awaited_msgs.push_back(m);
		end
	endtask

	task automatic check_msg();
		mbsma_pkg::msg_t want;
		if (awaited_msgs.size() == 0) begin
			$error("unexpected message transaction: status %0h", msg_status);
			errors++;
			return;
		end
		want = awaited_msgs.pop_front();
		if (msg_status !== want.status) begin
			$error("msg_status: expected %0h, actual %0h", want.status, msg_status);
			errors++;
		end
		if (msg_first_data !== want.first) begin
			$error("msg_first_data: expected %0h, actual %0h", want.first, msg_first_data);
			errors++;
		end
		if (msg_second_data !== want.second) begin
			$error("msg_second_data: expected %0h, actual %0h", want.second, msg_second_data);
			errors++;
		end
		if (msg_data_count !== want.count) begin
			$error("msg_data_count: expected %0d, actual %0d", want.count, msg_data_count);
			errors++;
		end
		if (msg_last !== want.last) begin
			$error("msg_last: expected %0b, actual %0b", want.last, msg_last);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lose_sync();
			awaited_msgs.delete();
			errors = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				parse_byte(rx_byte);
			end
			if (msg_valid && !msg_stall) begin
				check_msg();
			end
			fail_count  <= errors;
			outstanding <= awaited_msgs.size();
		end
	end

endmodule

/* tb/tb_midi_byte_stream_message_assembler.sv */
`timescale 1ns / 1ps
// Top of the testbench for the MIDI byte stream message assembler: clock, reset, byte
// stimulus and receiver stalls, and the final verdict. Depends on mbsma_pkg, the block
// and midi_msg_checker.
module tb_midi_byte_stream_message_assembler;

	localparam int CYCLE_LIMIT = 200000;
	localparam int BYTE_TARGET = 2000;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] rx_byte;
	logic       msg_valid;
	logic       msg_stall = 1'b0;
	logic [7:0] msg_status;
	logic [6:0] msg_first_data;
	logic [6:0] msg_second_data;
	logic [1:0] msg_data_count;
	logic       msg_last;
	int         fail_count;
	int         outstanding;
	int         cycles = 0;
	int         bytes_sent;
	bit         no_idle;

	midi_byte_stream_message_assembler uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.rx_byte         (rx_byte),
		.msg_valid       (msg_valid),
		.msg_stall       (msg_stall),
		.msg_status      (msg_status),
		.msg_first_data  (msg_first_data),
		.msg_second_data (msg_second_data),
		.msg_data_count  (msg_data_count),
		.msg_last        (msg_last)
	);

	midi_msg_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.rx_byte         (rx_byte),
		.msg_valid       (msg_valid),
		.msg_stall       (msg_stall),
		.msg_status      (msg_status),
		.msg_first_data  (msg_first_data),
		.msg_second_data (msg_second_data),
		.msg_data_count  (msg_data_count),
		.msg_last        (msg_last),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		msg_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 33);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[midi_byte_stream_message_assembler] ERROR");
			$finish;
		end
	end

	// Each transaction may be preceded by a short idle gap on the byte channel.
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte    <= b;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
	endtask

	task automatic send_mixed(input logic [7:0] b);
		if ($urandom_range(0, 99) < 6) begin
			send_byte({mbsma_pkg::RT_FIRST[7:3], 3'($urandom_range(0, 7))});
		end
		send_byte(b);
	endtask

	task automatic send_data();
		send_mixed({1'b0, 7'($urandom_range(0, 127))});
	endtask

	task automatic wait_for_drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] any_channel_status();
		return {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
	endfunction

	initial begin
		logic [7:0] directed [$];
		int kind;
		bit paused;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		rx_byte    = '0;
		no_idle    = 1'b0;
		bytes_sent = 0;
		paused     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{8'h00, mbsma_pkg::SX_END, mbsma_pkg::RT_FIRST, mbsma_pkg::RT_UNDEF_A,
			mbsma_pkg::RT_UNDEF_B, 8'h90, 8'h7F, 8'h00, 8'h55, 8'h2A, 8'hC3, 8'h7F, 8'hF2,
			8'h01, 8'h7E, 8'hF1, 8'h10, 8'hF3, 8'h05, mbsma_pkg::TUNE_REQ, 8'h40, 8'hE0,
			8'h7F, mbsma_pkg::SX_START, 8'h12, 8'hFE, 8'h80, 8'h01, 8'h02,
			mbsma_pkg::SX_START, 8'h33, mbsma_pkg::TUNE_REQ, mbsma_pkg::SX_START,
			mbsma_pkg::SX_END, 8'hB0, 8'h10, 8'hD5, 8'hF5, 8'hA0, 8'h7F, 8'h7F,
			mbsma_pkg::SX_START, 8'hF4, 8'hFF};
		foreach (directed[i]) begin
			send_byte(directed[i]);
		end
		wait_for_drain();

		while (bytes_sent < BYTE_TARGET) begin
			if (!paused && bytes_sent >= 900) begin
				wait_for_drain();
				paused = 1'b1;
			end
			no_idle = (bytes_sent >= 1300 && bytes_sent < 1600);
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				send_mixed(any_channel_status());
				send_data();
				send_data();
				repeat ($urandom_range(0, 3)) begin
					send_data();
					send_data();
				end
			end else if (kind < 68) begin
				send_mixed(8'($urandom_range(mbsma_pkg::SX_START + 1, mbsma_pkg::TUNE_REQ)));
				repeat ($urandom_range(0, 2)) send_data();
			end else if (kind < 85) begin
				send_mixed(mbsma_pkg::SX_START);
				repeat ($urandom_range(0, 6)) send_data();
				if ($urandom_range(0, 99) < 60) begin
					send_mixed(mbsma_pkg::SX_END);
				end else begin
					send_mixed(8'($urandom_range(mbsma_pkg::CHAN_FIRST, mbsma_pkg::SX_END)));
				end
			end else if (kind < 93) begin
				send_mixed(any_channel_status());
				send_data();
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		no_idle = 1'b0;

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("[midi_byte_stream_message_assembler] OK");
		end else begin
			$display("[midi_byte_stream_message_assembler] ERROR");
		end
		$finish;
	end

endmodule
